>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/fssa_pkg.sv
// Shared constants and elaboration-time helpers for the splat accumulator.
package fssa_pkg;

  localparam int MAX_SIDE_DEF  = 256;
  localparam int EXP_DEPTH_DEF = 256;

  localparam int SUM_W  = 40;
  localparam int WSUM_W = 32;
  localparam int WORD_W = 3 * SUM_W + WSUM_W;

  localparam logic [1:0] MODE_BOX   = 2'd0;
  localparam logic [1:0] MODE_TRI   = 2'd1;
  localparam logic [1:0] MODE_GAUSS = 2'd2;

  localparam logic CMD_SPLAT = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_MODE   = 3'd2;
  localparam logic [2:0] REG_ALPHA  = 3'd3;
  localparam logic [2:0] REG_OFFSET = 3'd4;

  // Q30 exp(-h) from its alternating Taylor series up to the h^16 term.
  function automatic logic [63:0] exp_ratio(input logic [63:0] h);
    logic [63:0] term;
    logic [63:0] r;
    term = 64'd1 << 30;
    r    = 64'd1 << 30;
    for (int n = 1; n <= 16; n++) begin
      term = ((term * h) >> 30) / 64'(n);
      if (n % 2 == 1) r = r - term;
      else r = r + term;
    end
    return r;
  endfunction

  // Table entry k: Q30 power of the ratio, rounded to Q1.16.
  function automatic logic [16:0] exp_entry(input logic [63:0] r, input int k);
    logic [63:0] e;
    e = 64'd1 << 30;
    for (int i = 0; i < k; i++) e = (e * r) >> 30;
    return 17'((e + 64'd8192) >> 14);
  endfunction

endpackage

>>> hw/rtl/fssa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module fssa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/filtered_sample_splat_accumulator_unit.sv
// Film splat accumulator: filtered 2x2 sample splatting into a frame store.
// After reset the frame store is cleared, one entry a cycle, over all MAX_SIDE*MAX_SIDE
// entries; requests wait, APB writes are taken as ever.
// One request at a time. A read request's response comes from the frame store's
// registered read, is registered onto the response outputs and waits on rsp_ready.
// A splat request visits its four pixels in turn: a pixel outside the film takes the
// first of seven steps only, one inside takes all seven (distance and square, gaussian
// argument, table index, table lookup, weight with store read, colour products,
// saturating write-back), and no new request is taken until all four are done.
// The single read port and single write port of the frame store are each used once
// per pixel inside the film. Registers: 0 width, 1 height, 2 filter mode,
// 3 gaussian alpha (Q8.8), 4 gaussian offset (Q0.16), at byte addresses 4*i.
module filtered_sample_splat_accumulator_unit #(
  parameter int MAX_SIDE        = fssa_pkg::MAX_SIDE_DEF,
  parameter int EXP_TABLE_DEPTH = fssa_pkg::EXP_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        cmd,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [15:0] red,
  input  logic [15:0] green,
  input  logic [15:0] blue,
  input  logic [15:0] read_index,
  // response channel
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [39:0] sum_red,
  output logic [39:0] sum_green,
  output logic [39:0] sum_blue,
  output logic [31:0] sum_weight
);

  `include "assert_macros.svh"

  localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int TW          = $clog2(EXP_TABLE_DEPTH);
  localparam int PW          = 29 + TW;
  localparam int SW          = fssa_pkg::SUM_W;
  localparam int WW          = fssa_pkg::WSUM_W;
  localparam logic [63:0] EXP_H = (64'd16 << 30) / EXP_TABLE_DEPTH;
  localparam logic [63:0] EXP_R = fssa_pkg::exp_ratio(EXP_H);

  // fixed exp table, Q1.16
  logic [16:0] exp_tab [EXP_TABLE_DEPTH];
  for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_exp
    assign exp_tab[k] = fssa_pkg::exp_entry(EXP_R, k);
  end

  // ---------------- configuration ----------------
  logic [8:0]  frame_width, frame_height;
  logic [1:0]  filter_mode;
  logic [15:0] gauss_alpha, gauss_offset;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 9'd256;
      frame_height <= 9'd256;
      filter_mode  <= fssa_pkg::MODE_BOX;
      gauss_alpha  <= 16'd512;
      gauss_offset <= 16'd0;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        fssa_pkg::REG_WIDTH:  frame_width  <= pwdata[8:0];
        fssa_pkg::REG_HEIGHT: frame_height <= pwdata[8:0];
        fssa_pkg::REG_MODE:   filter_mode  <= pwdata[1:0];
        fssa_pkg::REG_ALPHA:  gauss_alpha  <= pwdata[15:0];
        fssa_pkg::REG_OFFSET: gauss_offset <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      fssa_pkg::REG_WIDTH:  prdata = {23'd0, frame_width};
      fssa_pkg::REG_HEIGHT: prdata = {23'd0, frame_height};
      fssa_pkg::REG_MODE:   prdata = {30'd0, filter_mode};
      fssa_pkg::REG_ALPHA:  prdata = {16'd0, gauss_alpha};
      fssa_pkg::REG_OFFSET: prdata = {16'd0, gauss_offset};
      default:              prdata = 32'd0;
    endcase
  end

  // film extent, clipped to the store side
  logic [8:0] stride, height;
  assign stride = (32'(frame_width) < MAX_SIDE)  ? frame_width  : 9'(MAX_SIDE);
  assign height = (32'(frame_height) < MAX_SIDE) ? frame_height : 9'(MAX_SIDE);

  // ---------------- sequencer ----------------
  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SQ, ST_ARG, ST_IDX, ST_EXP, ST_WGT, ST_MUL, ST_WR, ST_RD
  } state_t;

  state_t state;
  logic [AW-1:0] clr_addr;
  logic [1:0]    pix;
  logic          rd_zero;

  // held request
  logic [15:0] hx, hy, hr, hg, hb;
  logic [7:0]  bx, by;

  // per-pixel datapath registers
  logic [AW-1:0] pix_addr;
  logic [33:0]   sqx, sqy;
  logic [8:0]    trix, triy;
  logic [43:0]   tx, ty;
  logic          bigx, bigy, okx, oky;
  logic [TW-1:0] idxx, idxy;
  logic [16:0]   gx, gy;
  logic [16:0]   w;
  logic [24:0]   pr, pg, pb;

  // current pixel geometry
  logic [8:0]         px, py;
  logic               inb;
  logic signed [17:0] dx, dy;
  logic [16:0]        ax, ay;
  logic [17:0]        lin;

  assign px  = {1'b0, bx} + 9'(pix[0]);
  assign py  = {1'b0, by} + 9'(pix[1]);
  assign inb = (px < stride) && (py < height);
  assign dx  = $signed({2'b00, hx}) - $signed({1'b0, px, 8'h80});
  assign dy  = $signed({2'b00, hy}) - $signed({1'b0, py, 8'h80});
  assign ax  = dx[17] ? 17'(-dx) : 17'(dx);
  assign ay  = dy[17] ? 17'(-dy) : 17'(dy);
  assign lin = 18'(px) + 18'(py) * 18'(stride);

  logic [PW-1:0] prodx, prody;
  assign prodx = PW'(tx[27:0]) * PW'(EXP_TABLE_DEPTH);
  assign prody = PW'(ty[27:0]) * PW'(EXP_TABLE_DEPTH);

  logic [16:0] ex, ey;
  assign ex = exp_tab[idxx];
  assign ey = exp_tab[idxy];

  logic [33:0] gprod;
  logic [17:0] tprod;
  assign gprod = 34'(gx) * 34'(gy);
  assign tprod = 18'(trix) * 18'(triy);

  // frame store
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [fssa_pkg::WORD_W-1:0] ram_wdata, ram_rdata;
  logic                req_fire, rd_in_range;

  assign req_ready   = (state == ST_IDLE);
  assign req_fire    = req_valid && req_ready;
  assign rd_in_range = (32'(read_index) < STORE_DEPTH);

  // saturating accumulation
  logic [SW-1:0] old_r, old_g, old_b;
  logic [WW-1:0] old_w;
  logic [SW:0]   nr, ng, nb;
  logic [WW:0]   nw;
  assign {old_r, old_g, old_b, old_w} = ram_rdata;
  assign nr = {1'b0, old_r} + (SW+1)'(pr);
  assign ng = {1'b0, old_g} + (SW+1)'(pg);
  assign nb = {1'b0, old_b} + (SW+1)'(pb);
  assign nw = {1'b0, old_w} + (WW+1)'(w);

  assign ram_we    = (state == ST_CLEAR) || (state == ST_WR);
  assign ram_waddr = (state == ST_CLEAR) ? clr_addr : pix_addr;
  assign ram_wdata = (state == ST_CLEAR) ? '0 :
                     {nr[SW] ? {SW{1'b1}} : nr[SW-1:0],
                      ng[SW] ? {SW{1'b1}} : ng[SW-1:0],
                      nb[SW] ? {SW{1'b1}} : nb[SW-1:0],
                      nw[WW] ? {WW{1'b1}} : nw[WW-1:0]};
  assign ram_re    = (req_fire && cmd == fssa_pkg::CMD_READ && rd_in_range)
                     || (state == ST_WGT);
  assign ram_raddr = (state == ST_WGT) ? pix_addr : AW'(read_index);

  fssa_ram #(.WIDTH(fssa_pkg::WORD_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      pix       <= 2'd0;
      rsp_valid <= 1'b0;
    end else begin
      // ST_RD owns the response flag while it runs
      if (rsp_valid && rsp_ready && state != ST_RD) rsp_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(STORE_DEPTH - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (req_fire) begin
            hx <= pos_x;
            hy <= pos_y;
            hr <= red;
            hg <= green;
            hb <= blue;
            // base pixel: position less one half, truncated, floor at zero
            bx <= (pos_x >= 16'd128) ? 8'((pos_x - 16'd128) >> 8) : 8'd0;
            by <= (pos_y >= 16'd128) ? 8'((pos_y - 16'd128) >> 8) : 8'd0;
            pix <= 2'd0;
            rd_zero <= !rd_in_range;
            state <= (cmd == fssa_pkg::CMD_READ) ? ST_RD : ST_SQ;
          end
        end
        ST_SQ: begin
          sqx      <= 34'(ax) * 34'(ax);
          sqy      <= 34'(ay) * 34'(ay);
          trix     <= (ax < 17'd256) ? 9'(17'd256 - ax) : 9'd0;
          triy     <= (ay < 17'd256) ? 9'(17'd256 - ay) : 9'd0;
          pix_addr <= AW'(lin);
          if (inb) state <= ST_ARG;
          else if (pix == 2'd3) state <= ST_IDLE;
          else pix <= pix + 2'd1;
        end
        ST_ARG: begin
          // a square at or past 2^28 with non-zero alpha runs off the table
          bigx  <= (sqx[33:28] != 6'd0) && (gauss_alpha != 16'd0);
          bigy  <= (sqy[33:28] != 6'd0) && (gauss_alpha != 16'd0);
          tx    <= 44'(gauss_alpha) * 44'(sqx[27:0]);
          ty    <= 44'(gauss_alpha) * 44'(sqy[27:0]);
          state <= ST_IDX;
        end
        ST_IDX: begin
          okx   <= !bigx && (tx[43:28] == 16'd0);
          oky   <= !bigy && (ty[43:28] == 16'd0);
          idxx  <= prodx[28 +: TW];
          idxy  <= prody[28 +: TW];
          state <= ST_EXP;
        end
        ST_EXP: begin
          gx <= (okx && ex > 17'(gauss_offset)) ? ex - 17'(gauss_offset) : 17'd0;
          gy <= (oky && ey > 17'(gauss_offset)) ? ey - 17'(gauss_offset) : 17'd0;
          state <= ST_WGT;
        end
        ST_WGT: begin
          priority case (filter_mode)
            fssa_pkg::MODE_TRI:   w <= 17'(tprod);
            fssa_pkg::MODE_GAUSS: w <= 17'(gprod >> 16);
            default:              w <= 17'h10000;  // box, and the unused code
          endcase
          state <= ST_MUL;
        end
        ST_MUL: begin
          pr    <= 25'((33'(hr) * 33'(w)) >> 8);
          pg    <= 25'((33'(hg) * 33'(w)) >> 8);
          pb    <= 25'((33'(hb) * 33'(w)) >> 8);
          state <= ST_WR;
        end
        ST_WR: begin
          if (pix == 2'd3) state <= ST_IDLE;
          else begin
            pix   <= pix + 2'd1;
            state <= ST_SQ;
          end
        end
        ST_RD: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid  <= 1'b1;
            sum_red    <= rd_zero ? '0 : old_r;
            sum_green  <= rd_zero ? '0 : old_g;
            sum_blue   <= rd_zero ? '0 : old_b;
            sum_weight <= rd_zero ? '0 : old_w;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_no_req_in_clear, clk, rst, (state == ST_CLEAR) |-> !req_ready, "request taken during clear")
  `ASSERT_CLK(a_one_port_use, clk, rst, ram_we |-> !ram_re, "store read and write together")
  `ASSERT_CLK(a_rd_waits, clk, rst, (state == ST_RD && rsp_valid && !rsp_ready) |=> (state == ST_RD && rsp_valid), "response overwritten")

endmodule
